>>> design/gbfs_pkg.sv
// Package for the grid breadth-first path finder: request/result structs,
// controller command/status structs and grid constants. No dependencies.
`default_nettype none
package gbfs_pkg;
	localparam int GRID_SIZE = 16;
	localparam int CW = 4;
	localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;
	localparam int IW = 2 * CW;
	localparam int PATH_MAX = 15;
	localparam int PW = 4;

	typedef struct packed {
		logic [3:0] start_x;
		logic [3:0] start_y;
		logic [3:0] end_x;
		logic [3:0] end_y;
	} req_t;

	typedef struct packed {
		logic [3:0] cell_x;
		logic [3:0] cell_y;
		logic [2:0] came_from;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic deq;
		logic step;
		logic walk_init;
		logic walk;
		logic emit;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic same;
		logic q_empty;
		logic found;
		logic last_dir;
		logic walk_done;
		logic emit_done;
	} sts_t;
endpackage
`default_nettype wire

>>> design/grid_bfs_path_finder_unit.sv
// Grid breadth-first path finder on a 16x16 8-connected grid. One request
// at a time: the search dequeues each cell and tries its neighbors in turn,
// then walks back from the end cell to build the path, then emits one result
// per path cell. A request with start equal to end gives no result.
// Depends on gbfs_pkg, gbfs_ctrl, gbfs_datapath, gbfs_ram.
`default_nettype none
module grid_bfs_path_finder_unit import gbfs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire req_t in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output rsp_t      out_data
);
	cmd_t cmd;
	sts_t sts;

	gbfs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd));

	gbfs_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .req(in_data), .cmd(cmd), .sts(sts),
		.rsp(out_data));

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.load, cmd.deq, cmd.step, cmd.walk, cmd.out_load}) <= 1)
		else $error("multiple datapath commands");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !in_ready)
		else $error("request accepted during search");
endmodule
`default_nettype wire

>>> design/gbfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module gbfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> design/gbfs_datapath.sv
// Datapath: visited bits, queue and parent-direction RAMs, neighbor step,
// walk back and path stack. Depends on gbfs_pkg and gbfs_ram.
`default_nettype none
module gbfs_datapath import gbfs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire req_t req,
	input  wire cmd_t cmd,
	output sts_t      sts,
	output rsp_t      rsp
);
	function automatic logic [CW-1:0] clampc(input logic [3:0] v);
		if (32'(v) >= GRID_SIZE) return CW'(GRID_SIZE - 1);
		return CW'(v);
	endfunction

	logic [CELL_COUNT-1:0] vis_q;
	logic [CW-1:0] dx_q, dy_q, cx_q, cy_q, wx_q, wy_q;
	logic [IW-1:0] src_q;
	logic [8:0] head_q, tail_q;
	logic [2:0] d_q;
	logic found_q, walk_done_q;
	logic [IW-1:0] stack_q [PATH_MAX];
	logic [PW-1:0] cnt_q, k_q;
	logic [IW-1:0] ecell_q;

	// neighbor for direction d_q
	logic [CW:0] nx, ny;
	logic inb, take;
	logic [IW-1:0] n;
	always_comb begin
		nx = {1'b0, cx_q};
		ny = {1'b0, cy_q};
		case (d_q)
			3'd0: begin nx = nx - 1'b1; ny = ny - 1'b1; end
			3'd1: ny = ny - 1'b1;
			3'd2: begin nx = nx + 1'b1; ny = ny - 1'b1; end
			3'd3: nx = nx - 1'b1;
			3'd4: nx = nx + 1'b1;
			3'd5: begin nx = nx - 1'b1; ny = ny + 1'b1; end
			3'd6: ny = ny + 1'b1;
			default: begin nx = nx + 1'b1; ny = ny + 1'b1; end
		endcase
		inb = (32'(nx) < GRID_SIZE) && (32'(ny) < GRID_SIZE);
		n = {ny[CW-1:0], nx[CW-1:0]};
		take = cmd.step && inb && !vis_q[n];
	end

	// queue RAM: read at head, write at tail
	logic [IW-1:0] src_in, dst_in;
	assign src_in = {clampc(req.start_y), clampc(req.start_x)};
	assign dst_in = {clampc(req.end_y), clampc(req.end_x)};
	logic q_we;
	logic [IW-1:0] q_wd, q_rd;
	assign q_we = cmd.load || (take && tail_q < 9'(CELL_COUNT));
	assign q_wd = cmd.load ? src_in : n;

	gbfs_ram #(.WIDTH(IW), .DEPTH(CELL_COUNT)) u_queue (
		.clk(clk), .we(q_we), .waddr(cmd.load ? '0 : tail_q[IW-1:0]),
		.wdata(q_wd), .raddr(head_q[IW-1:0]), .rdata(q_rd));

	// parent RAM: read at walk cell or emit cell
	logic [2:0] p_rd;
	logic [IW-1:0] p_ra, wcell, ecell;
	assign wcell = {wy_q, wx_q};
	assign ecell = stack_q[cnt_q - k_q - 1'b1];
	assign p_ra = cmd.emit ? ecell : wcell;
	gbfs_ram #(.WIDTH(3), .DEPTH(CELL_COUNT)) u_parent (
		.clk(clk), .we(take), .waddr(n), .wdata(3'd7 - d_q),
		.raddr(p_ra), .rdata(p_rd));

	// walk: p_rd holds parent dir of wcell (read in the previous cycle)
	logic [CW:0] px, py;
	always_comb begin
		px = {1'b0, wx_q};
		py = {1'b0, wy_q};
		case (p_rd)
			3'd0: begin px = px - 1'b1; py = py - 1'b1; end
			3'd1: py = py - 1'b1;
			3'd2: begin px = px + 1'b1; py = py - 1'b1; end
			3'd3: px = px - 1'b1;
			3'd4: px = px + 1'b1;
			3'd5: begin px = px - 1'b1; py = py + 1'b1; end
			3'd6: py = py + 1'b1;
			default: begin px = px + 1'b1; py = py + 1'b1; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			d_q <= '0;
			found_q <= 1'b0;
			walk_done_q <= 1'b0;
			cnt_q <= '0;
			k_q <= '0;
		end else begin
			if (cmd.load) begin
				vis_q <= CELL_COUNT'(1) << src_in;
				head_q <= '0;
				tail_q <= 9'd1;
				found_q <= 1'b0;
				src_q <= src_in;
				{dy_q, dx_q} <= dst_in;
			end
			if (cmd.deq) begin
				{cy_q, cx_q} <= q_rd;
				head_q <= head_q + 1'b1;
				d_q <= '0;
			end
			if (cmd.step) begin
				d_q <= d_q + 1'b1;
				if (take) begin
					vis_q[n] <= 1'b1;
					if (tail_q < 9'(CELL_COUNT)) tail_q <= tail_q + 1'b1;
					if (n == {dy_q, dx_q}) found_q <= 1'b1;
				end
			end
			if (cmd.walk_init) begin
				wx_q <= dx_q;
				wy_q <= dy_q;
				cnt_q <= '0;
				walk_done_q <= 1'b0;
				k_q <= '0;
			end
			if (cmd.walk) begin
				stack_q[cnt_q] <= wcell;
				cnt_q <= cnt_q + 1'b1;
				if (32'(px) >= GRID_SIZE || 32'(py) >= GRID_SIZE
				    || {py[CW-1:0], px[CW-1:0]} == src_q
				    || cnt_q == PW'(PATH_MAX - 1))
					walk_done_q <= 1'b1;
				wx_q <= px[CW-1:0];
				wy_q <= py[CW-1:0];
			end
			if (cmd.out_load) k_q <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp.cell_x <= 4'(ecell_q[CW-1:0]);
			rsp.cell_y <= 4'(ecell_q[IW-1:CW]);
			rsp.came_from <= p_rd;
			rsp.last <= (k_q == cnt_q - 1'b1);
		end
		if (cmd.emit) ecell_q <= ecell;
	end

	assign sts.same = (src_in == dst_in);
	assign sts.q_empty = (head_q == tail_q);
	assign sts.found = found_q;
	assign sts.last_dir = (d_q == 3'd7) || (take && n == {dy_q, dx_q});
	assign sts.walk_done = walk_done_q;
	assign sts.emit_done = (k_q == cnt_q);
endmodule
`default_nettype wire

>>> design/gbfs_ctrl.sv
// Controller state machine: sequences search, walk back and result output.
// Depends on gbfs_pkg.
`default_nettype none
module gbfs_ctrl import gbfs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_RDQ   = 8'b00000010,
		S_DEQ   = 8'b00000100,
		S_STEP  = 8'b00001000,
		S_WRD   = 8'b00010000,
		S_WALK  = 8'b00100000,
		S_ERD   = 8'b01000000,
		S_OUT   = 8'b10000000
	} state_t;
	state_t st_q, st_d;
	logic ov_q, ov_d;

	assign in_ready = (st_q == S_IDLE) && !ov_q;
	assign out_valid = ov_q;

	always_comb begin
		st_d = st_q;
		ov_d = ov_q;
		cmd = '0;
		if (ov_q && out_ready) ov_d = 1'b0;
		case (st_q)
			S_IDLE: begin
				if (in_valid && in_ready && !sts.same) begin
					cmd.load = 1'b1;
					st_d = S_RDQ;
				end
			end
			S_RDQ: begin
				if (sts.found) begin
					cmd.walk_init = 1'b1;
					st_d = S_WRD;
				end else if (sts.q_empty) st_d = S_IDLE;
				else st_d = S_DEQ;
			end
			S_DEQ: begin
				cmd.deq = 1'b1;
				st_d = S_STEP;
			end
			S_STEP: begin
				cmd.step = 1'b1;
				if (sts.last_dir) st_d = S_RDQ;
			end
			S_WRD: st_d = S_WALK;
			S_WALK: begin
				if (sts.walk_done) st_d = S_ERD;
				else begin
					cmd.walk = 1'b1;
					st_d = S_WRD;
				end
			end
			S_ERD: begin
				if (sts.emit_done) st_d = S_IDLE;
				else if (!ov_q || out_ready) begin
					cmd.emit = 1'b1;
					st_d = S_OUT;
				end
			end
			S_OUT: begin
				cmd.out_load = 1'b1;
				ov_d = 1'b1;
				st_d = S_ERD;
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			ov_q <= ov_d;
		end
	end
endmodule
`default_nettype wire
